@@ sv/dl2n_pkg.sv @@
// Package for the descriptor L2 normalizer: widths, payload structs,
// the front-to-back queue entry, the back-end state type and small helpers.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dl2n_pkg;

  localparam int ROW_LEN  = 64;
  localparam int ELEM_W   = 16;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = 6;
  localparam int SUM_W    = 37;
  localparam int SQ_W     = 32;
  localparam int REM_W    = 38;
  localparam int QUO_W    = 33;
  localparam int ROOT_W   = 17;
  localparam int ODD_W    = 18;
  localparam int ITER_W   = 6;
  localparam int BIT_W    = 5;
  localparam int Q_DEPTH  = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  // The quotient has 33 bits; the division counts from bit 32 down to bit 0.
  localparam logic [ITER_W-1:0] DIV_FIRST  = ITER_W'(QUO_W - 1);
  localparam logic [BIT_W-1:0]  ROOT_FIRST = BIT_W'(ROOT_W - 1);
  localparam logic [ROOT_W-1:0] MAG_POS_MAX = ROOT_W'(32767);
  localparam logic [ROOT_W-1:0] MAG_NEG_MAX = ROOT_W'(32768);

  typedef struct packed {
    logic signed [ELEM_W-1:0] in_value;
    logic                     in_last;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] out_value;
    logic                     out_last;
    logic                     zero_norm;
    logic                     too_long;
  } out_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     store;
    logic                     close;
    logic [ADDR_W-1:0]        idx;
    logic [CNT_W-1:0]         count;
    logic                     ovf;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_POP,
    ST_SETTLE,
    ST_READ,
    ST_SQUARE,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } back_state_e;

  function automatic logic [ELEM_W-1:0] abs_elem(input logic [ELEM_W-1:0] x);
    logic [ELEM_W-1:0] r;
    r = x[ELEM_W-1] ? ELEM_W'(~x + 1'b1) : x;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/descriptor_l2_normalizer_core.sv @@
// Top level of the descriptor L2 normalizer: front end, queue, back end.
// Depends on dl2n_pkg, dl2n_front, dl2n_queue and dl2n_back.
`timescale 1ns / 1ps
`default_nettype none
// Elements of a descriptor row enter one per cycle while the four-entry queue
// has room; the item flagged last closes the row, and up to 64 elements are
// kept (later ones are dropped and too_long is set on the row's results).
// Each stored element is then emitted as x * 2^15 / sqrt(sum of squares) in
// Q1.15, rounded to nearest and saturated to the Q1.15 range. Per result the
// back end runs a memory read, a squaring, a 33-step restoring divider and a
// 17-step square-root search, one bit per cycle each, plus a settling state
// per row. A row with zero sum skips the divider and root. While a row is
// emitted, up to four items of the next row wait in the queue.
module descriptor_l2_normalizer_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dl2n_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dl2n_pkg::out_item_t      out_data_o
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  dl2n_pkg::q_entry_t q_in;
  dl2n_pkg::q_entry_t q_head;

  dl2n_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  dl2n_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  dl2n_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_zero_row_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_norm) |-> (out_data_o.out_value == '0))
    else $error("zero-norm result with nonzero value");

endmodule
`default_nettype wire

@@ sv/dl2n_front.sv @@
// Front end of the descriptor L2 normalizer: accepts elements, tracks the
// row length and overflow, and pushes store and close entries to the queue.
// Depends on dl2n_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dl2n_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire dl2n_pkg::in_item_t in_data_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output dl2n_pkg::q_entry_t      entry_o
);

  logic [dl2n_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       ovf_q, ovf_d;
  logic                       accept;
  logic                       store;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign store      = cnt_q < dl2n_pkg::CNT_W'(dl2n_pkg::ROW_LEN);

  always_comb begin
    entry_o.value = in_data_i.in_value;
    entry_o.store = store;
    entry_o.close = in_data_i.in_last;
    entry_o.idx   = cnt_q[dl2n_pkg::ADDR_W-1:0];
    entry_o.count = store ? dl2n_pkg::CNT_W'(cnt_q + 1'b1) : cnt_q;
    entry_o.ovf   = ovf_q || !store;
  end

  // A dropped element that is not the last of its row only needs to mark
  // the overflow, so it never enters the queue.
  assign push_o = accept && (store || in_data_i.in_last);

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (in_data_i.in_last) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = entry_o.count;
        ovf_d = entry_o.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/dl2n_queue.sv @@
// Short queue between the front and back ends of the normalizer.
// Depends on dl2n_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dl2n_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire dl2n_pkg::q_entry_t entry_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output dl2n_pkg::q_entry_t      head_o
);

  dl2n_pkg::q_entry_t          slot_q [dl2n_pkg::Q_DEPTH];
  logic [dl2n_pkg::QPTR_W-1:0] wr_q, wr_d;
  logic [dl2n_pkg::QPTR_W-1:0] rd_q, rd_d;
  logic [dl2n_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == dl2n_pkg::QCNT_W'(dl2n_pkg::Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? dl2n_pkg::QPTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = pop_i ? dl2n_pkg::QPTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = dl2n_pkg::QCNT_W'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = dl2n_pkg::QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/dl2n_back.sv @@
// Back end of the normalizer: row memory, sum of squares, restoring divider
// and bit-by-bit square root, and the output register.
// Depends on dl2n_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dl2n_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dl2n_pkg::q_entry_t head_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output dl2n_pkg::out_item_t     out_data_o
);

  dl2n_pkg::back_state_e state_q, state_d;

  logic [dl2n_pkg::ELEM_W-1:0] row_mem [dl2n_pkg::ROW_LEN];
  logic                        mem_we;
  logic                        mem_re;
  logic [dl2n_pkg::ELEM_W-1:0] rd_q;

  logic [dl2n_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [dl2n_pkg::SQ_W-1:0]   sq_q, sq_d;
  logic                        sq_vld_q, sq_vld_d;
  logic [dl2n_pkg::CNT_W-1:0]  n_q, n_d;
  logic [dl2n_pkg::CNT_W-1:0]  k_q, k_d;
  logic                        ovf_q, ovf_d;
  logic                        zero_q, zero_d;
  logic [dl2n_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [dl2n_pkg::QUO_W-1:0]  quo_q, quo_d;
  logic [dl2n_pkg::ITER_W-1:0] it_q, it_d;
  logic [dl2n_pkg::ROOT_W-1:0] root_q, root_d;
  logic [dl2n_pkg::BIT_W-1:0]  bit_q, bit_d;
  dl2n_pkg::out_item_t         out_q, out_d;
  logic                        ovld_q, ovld_d;

  logic [dl2n_pkg::ELEM_W-1:0] mul_a;
  logic [dl2n_pkg::SQ_W-1:0]   prod;
  logic [dl2n_pkg::REM_W-1:0]  div_t;
  logic [dl2n_pkg::REM_W-1:0]  div_s;
  logic                        div_ge;
  logic [dl2n_pkg::ROOT_W-1:0] cand;
  logic [dl2n_pkg::ODD_W-1:0]  odd;
  logic [2*dl2n_pkg::ODD_W-1:0] odd_sq;
  logic                        fits;
  logic [dl2n_pkg::ROOT_W-1:0] cap;
  logic                        k_last;
  logic                        out_free;

  // One squarer serves both the running sum and the per-element numerator.
  assign mul_a = (state_q == dl2n_pkg::ST_POP) ? dl2n_pkg::abs_elem(head_i.value)
                                                : dl2n_pkg::abs_elem(rd_q);
  assign prod  = dl2n_pkg::SQ_W'(mul_a * mul_a);

  // Numerator is x*x shifted up by 32, so only the first step can shift in a one bit (bit 0 of x*x).
  assign div_t  = {rem_q[dl2n_pkg::REM_W-2:0],
                   (it_q == dl2n_pkg::DIV_FIRST) ? sq_q[0] : 1'b0};
  assign div_s  = dl2n_pkg::REM_W'(sum_q);
  assign div_ge = div_t >= div_s;

  // Rounded root: largest n with (2n-1)^2 <= q.
  assign cand   = root_q | (dl2n_pkg::ROOT_W'(1) << bit_q);
  assign odd    = dl2n_pkg::ODD_W'({cand, 1'b0} - 1'b1);
  assign odd_sq = odd * odd;
  assign fits   = odd_sq <= (2*dl2n_pkg::ODD_W)'(quo_q);

  assign k_last   = dl2n_pkg::CNT_W'(k_q + 1'b1) == n_q;
  assign out_free = !ovld_q || !out_stall_i;

  always_comb begin
    if (rd_q[dl2n_pkg::ELEM_W-1]) begin
      cap = (root_q > dl2n_pkg::MAG_NEG_MAX) ? dl2n_pkg::MAG_NEG_MAX : root_q;
    end else begin
      cap = (root_q > dl2n_pkg::MAG_POS_MAX) ? dl2n_pkg::MAG_POS_MAX : root_q;
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    sq_d     = sq_q;
    sq_vld_d = 1'b0;
    sum_d    = sq_vld_q ? dl2n_pkg::SUM_W'(sum_q + dl2n_pkg::SUM_W'(sq_q)) : sum_q;
    n_d      = n_q;
    k_d      = k_q;
    ovf_d    = ovf_q;
    zero_d   = zero_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    it_d     = it_q;
    root_d   = root_q;
    bit_d    = bit_q;
    out_d    = out_q;
    ovld_d   = ovld_q && out_stall_i;
    case (state_q)
      dl2n_pkg::ST_POP: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.store) begin
            mem_we   = 1'b1;
            sq_d     = prod;
            sq_vld_d = 1'b1;
          end
          if (head_i.close) begin
            n_d     = head_i.count;
            ovf_d   = head_i.ovf;
            k_d     = '0;
            state_d = dl2n_pkg::ST_SETTLE;
          end
        end
      end
      // Lets the square of a final element that was also stored reach the sum.
      dl2n_pkg::ST_SETTLE: begin
        state_d = dl2n_pkg::ST_READ;
      end
      dl2n_pkg::ST_READ: begin
        mem_re  = 1'b1;
        zero_d  = sum_q == '0;
        state_d = dl2n_pkg::ST_SQUARE;
      end
      dl2n_pkg::ST_SQUARE: begin
        sq_d    = prod;
        rem_d   = dl2n_pkg::REM_W'(prod[dl2n_pkg::SQ_W-1:1]);
        quo_d   = '0;
        it_d    = dl2n_pkg::DIV_FIRST;
        state_d = zero_q ? dl2n_pkg::ST_EMIT : dl2n_pkg::ST_DIV;
      end
      dl2n_pkg::ST_DIV: begin
        rem_d = div_ge ? dl2n_pkg::REM_W'(div_t - div_s) : div_t;
        quo_d = {quo_q[dl2n_pkg::QUO_W-2:0], div_ge};
        it_d  = dl2n_pkg::ITER_W'(it_q - 1'b1);
        if (it_q == '0) begin
          root_d  = '0;
          bit_d   = dl2n_pkg::ROOT_FIRST;
          state_d = dl2n_pkg::ST_SQRT;
        end
      end
      dl2n_pkg::ST_SQRT: begin
        if (fits) begin
          root_d = cand;
        end
        bit_d = dl2n_pkg::BIT_W'(bit_q - 1'b1);
        if (bit_q == '0) begin
          state_d = dl2n_pkg::ST_EMIT;
        end
      end
      dl2n_pkg::ST_EMIT: begin
        if (out_free) begin
          ovld_d          = 1'b1;
          out_d.out_value = zero_q ? '0 :
                            (rd_q[dl2n_pkg::ELEM_W-1]
                               ? dl2n_pkg::ELEM_W'(dl2n_pkg::ROOT_W'(0) - cap)
                               : dl2n_pkg::ELEM_W'(cap));
          out_d.out_last  = k_last;
          out_d.zero_norm = zero_q;
          out_d.too_long  = ovf_q;
          k_d             = dl2n_pkg::CNT_W'(k_q + 1'b1);
          if (k_last) begin
            sum_d   = '0;
            state_d = dl2n_pkg::ST_POP;
          end else begin
            state_d = dl2n_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = dl2n_pkg::ST_POP;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[head_i.idx] <= head_i.value;
    end
    if (mem_re) begin
      rd_q <= row_mem[k_q[dl2n_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dl2n_pkg::ST_POP;
      sum_q    <= '0;
      sq_vld_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      sq_vld_q <= sq_vld_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    n_q    <= n_d;
    k_q    <= k_d;
    ovf_q  <= ovf_d;
    zero_q <= zero_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    it_q   <= it_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    out_q  <= out_d;
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ tb/descriptor_l2_normalizer_core_tb.sv @@
// Self-checking testbench for descriptor_l2_normalizer_core: sends descriptor rows and
// checks every normalized element against a predictor that runs alongside the block.
// Depends on dl2n_pkg and the RTL of the normalizer.
`timescale 1ns / 1ps
module descriptor_l2_normalizer_core_tb;

  localparam int QUIET_LIMIT = 1500;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 42;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  dl2n_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  dl2n_pkg::out_item_t out_data_o;

  // Predictor state: the open row and the results it will produce.
  logic signed [dl2n_pkg::ELEM_W-1:0] row_mem [dl2n_pkg::ROW_LEN];
  int unsigned                        row_len;
  logic [dl2n_pkg::SUM_W-1:0]         row_sumsq;
  bit                                 row_dropped;
  dl2n_pkg::out_item_t                pending_norm_q [$];

  bit idle_on = 1'b1;
  int error_count;
  int items_sent;
  int rows_closed;
  int zero_rows;
  int long_rows;
  int results_checked;
  int quiet_cycles;

  descriptor_l2_normalizer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Rounded |x| * 2^15 / sqrt(s): largest n with (2n-1)^2 <= x^2 * 2^32 / s.
  function automatic logic [63:0] norm_magnitude(input logic [63:0] ax,
                                                 input logic [dl2n_pkg::SUM_W-1:0] s);
    logic [63:0] q;
    logic [63:0] n;
    logic [63:0] cand;
    logic [63:0] odd;
    q = ((ax * ax) << 32) / 64'(s);
    n = '0;
    for (int b = 16; b >= 0; b--) begin
      cand = n | (64'd1 << b);
      odd = 64'd2 * cand - 64'd1;
      if (odd * odd <= q) n = cand;
    end
    return n;
  endfunction

  task automatic emit_row();
    dl2n_pkg::out_item_t r;
    logic [63:0]         ae;
    logic [63:0]         m;
    int                  e;
    for (int k = 0; k < int'(row_len); k++) begin
      e = row_mem[k];
      r = '0;
      if (row_sumsq != '0) begin
        ae = 64'(e < 0 ? -e : e);
        m = norm_magnitude(ae, row_sumsq);
        if (e < 0) begin
          if (m > 64'd32768) m = 64'd32768;
          r.out_value = dl2n_pkg::ELEM_W'(64'd0 - m);
        end else begin
          if (m > 64'd32767) m = 64'd32767;
          r.out_value = dl2n_pkg::ELEM_W'(m);
        end
      end
      r.out_last = (k + 1 == int'(row_len));
      r.zero_norm = (row_sumsq == '0);
      r.too_long = row_dropped;
      pending_norm_q.insert(pending_norm_q.size(), r);
    end
    rows_closed++;
    if (row_sumsq == '0) zero_rows++;
    if (row_dropped) long_rows++;
    row_len = 0;
    row_sumsq = '0;
    row_dropped = 1'b0;
  endtask

  task automatic absorb_element(input dl2n_pkg::in_item_t it);
    int          x;
    logic [63:0] mag;
    x = it.in_value;
    if (row_len < dl2n_pkg::ROW_LEN) begin
      row_mem[row_len] = it.in_value;
      row_len++;
      mag = 64'(x < 0 ? -x : x);
      row_sumsq = row_sumsq + dl2n_pkg::SUM_W'(mag * mag);
    end else begin
      row_dropped = 1'b1;
    end
    if (it.in_last) emit_row();
  endtask

  function automatic int input_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so that a following item can go out without a gap.
  task automatic send_element(input logic signed [dl2n_pkg::ELEM_W-1:0] value,
                              input bit last);
    int                 gap;
    dl2n_pkg::in_item_t it;
    gap = input_gap();
    it.in_value = value;
    it.in_last = last;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    absorb_element(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_row(input int vals[$]);
    foreach (vals[i]) send_element(dl2n_pkg::ELEM_W'(vals[i]), i == vals.size() - 1);
  endtask

  function automatic logic signed [dl2n_pkg::ELEM_W-1:0] random_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 4))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return 16'sd0;
        3: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    if (r < 25) return dl2n_pkg::ELEM_W'($urandom_range(0, 31)) - 16'sd16;
    return dl2n_pkg::ELEM_W'($urandom_range(0, 65535));
  endfunction

  task automatic test_single_extremes();
    idle_on = 1'b1;
    send_row('{32767});
    send_row('{-32768});
    send_row('{0});
  endtask

  task automatic test_zero_rows();
    send_row('{0, 0, 0});
  endtask

  task automatic test_known_ratios();
    idle_on = 1'b0;
    send_row('{-32768, 32767});
    send_row('{3, 4});
    send_row('{1, -1, 0, 1});
    idle_on = 1'b1;
    send_row('{1, 1, 1, 1});
    send_row('{-1, -1, -1, -1});
  endtask

  // One row that runs two past the full length: the store fills up, and both
  // an inner item and the closing item itself are dropped.
  task automatic test_full_and_overflow();
    idle_on = 1'b1;
    for (int i = 0; i < dl2n_pkg::ROW_LEN + 2; i++) begin
      send_element(random_element(), i == dl2n_pkg::ROW_LEN + 1);
    end
  endtask

  task automatic test_random_rows();
    int  sent;
    int  len;
    int  r;
    bit  zero_row;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      if (r < 65) len = $urandom_range(1, 6);
      else if (r < 90) len = $urandom_range(7, 16);
      else if (r < 97) len = $urandom_range(17, 40);
      else len = $urandom_range(60, 70);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      zero_row = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        send_element(zero_row ? 16'sd0 : random_element(), i == len - 1);
      end
      sent += len;
    end
  endtask

  // Output stall: mostly short bursts, now and then a long one.
  initial begin : out_stall_gen
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (idle_on && $urandom_range(0, 99) < 30) begin
        out_stall_i <= 1'b1;
        hold = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    dl2n_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_norm_q.size() == 0) begin
          report_error($sformatf("unexpected result, value %0d", out_data_o.out_value));
        end else begin
          want = pending_norm_q.pop_front();
          if (out_data_o.out_value !== want.out_value)
            report_error($sformatf("result %0d out_value: got %0d expected %0d",
                                   results_checked, out_data_o.out_value, want.out_value));
          if (out_data_o.out_last !== want.out_last)
            report_error($sformatf("result %0d out_last: got %b expected %b",
                                   results_checked, out_data_o.out_last, want.out_last));
          if (out_data_o.zero_norm !== want.zero_norm)
            report_error($sformatf("result %0d zero_norm: got %b expected %b",
                                   results_checked, out_data_o.zero_norm, want.zero_norm));
          if (out_data_o.too_long !== want.too_long)
            report_error($sformatf("result %0d too_long: got %b expected %b",
                                   results_checked, out_data_o.too_long, want.too_long));
          results_checked++;
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] Watchdog: no handshake for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_norm_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    row_len = 0;
    row_sumsq = '0;
    row_dropped = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_single_extremes();
    test_zero_rows();
    test_known_ratios();
    test_full_and_overflow();
    test_random_rows();

    in_valid_i <= 1'b0;
    idle_on = 1'b1;
    while (pending_norm_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_norm_q.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_norm_q.size()));

    $display("Sent %0d elements in %0d rows (%0d all-zero, %0d over length).",
             items_sent, rows_closed, zero_rows, long_rows);
    $display("Checked %0d normalized results, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
